/* hdl/rld_pkg.sv */
// Shared types and constants for the run-length decoder.
package rld_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int INDEX_W = 18;
  localparam int RUN_W   = 17;

  localparam logic [WORD_W-1:0] FLAG_ZERO_RUN = 16'hFFFF;
  localparam logic [WORD_W-1:0] FLAG_LITERAL  = 16'hFFFE;
  localparam int unsigned       INDEX_MAX     = 262143;

  typedef enum logic [2:0] {
    PH_FLAG_LO  = 3'd0,
    PH_FLAG_HI  = 3'd1,
    PH_ZERO_LO  = 3'd2,
    PH_ZERO_HI  = 3'd3,
    PH_LIT_LO   = 3'd4,
    PH_LIT_HI   = 3'd5,
    PH_LIT_DATA = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [BYTE_W-1:0]  low_byte_hold;
    logic [RUN_W-1:0]   literal_remaining;
  } rld_state_t;

  typedef struct packed {
    logic               emit;
    logic [INDEX_W-1:0] pixel_index;
    logic [BYTE_W-1:0]  pixel_value;
    logic [RUN_W-1:0]   run_length;
    logic               index_overflow;
  } rld_result_t;

endpackage

/* hdl/rld_step.sv */
// One decode step: next state and optional result for one stream byte.
module rld_step #(
  parameter int FRAME_PIXELS = 262144,
  parameter int POS_W        = 19
) (
  input  rld_pkg::rld_state_t  state,
  input  logic [POS_W-1:0]     position,
  input  logic [7:0]           data_byte,
  input  logic                 start_of_image,
  output rld_pkg::rld_state_t  state_next,
  output logic [POS_W-1:0]     position_next,
  output rld_pkg::rld_result_t result
);

  localparam int END_W = ((POS_W > rld_pkg::RUN_W) ? POS_W : rld_pkg::RUN_W) + 1;
  localparam int unsigned CAP_RAW = FRAME_PIXELS - 1;
  localparam int unsigned CAP = (CAP_RAW > rld_pkg::INDEX_MAX) ? rld_pkg::INDEX_MAX : CAP_RAW;
  localparam logic [END_W-1:0] CAP_E   = END_W'(CAP);
  localparam logic [END_W-1:0] FRAME_E = END_W'(FRAME_PIXELS);

  rld_pkg::phase_t                 phase;
  logic [rld_pkg::RUN_W-1:0]       lit;
  logic [POS_W-1:0]                pos;
  logic [rld_pkg::WORD_W-1:0]      word;
  logic [rld_pkg::RUN_W-1:0]       lit_load;
  logic [rld_pkg::RUN_W-1:0]       lit_dec;
  logic [rld_pkg::RUN_W-1:0]       run;
  logic                            emit;
  logic [7:0]                      value;
  logic [END_W-1:0]                pos_e;
  logic [END_W-1:0]                end_e;
  logic [END_W-1:0]                idx_e;
  logic                            ovf;

  assign phase    = start_of_image ? rld_pkg::PH_FLAG_LO : state.phase;
  assign lit      = start_of_image ? '0 : state.literal_remaining;
  assign pos      = start_of_image ? '0 : position;
  assign word     = {data_byte, state.low_byte_hold};
  assign lit_load = {word, 1'b0};
  assign lit_dec  = lit - rld_pkg::RUN_W'(1);

  always_comb begin
    state_next.phase             = rld_pkg::PH_FLAG_LO;
    state_next.low_byte_hold     = state.low_byte_hold;
    state_next.literal_remaining = lit;
    emit                         = 1'b0;
    value                        = '0;
    run                          = rld_pkg::RUN_W'(1);
    case (phase)
      rld_pkg::PH_FLAG_HI: begin
        if (word == rld_pkg::FLAG_ZERO_RUN) begin
          state_next.phase = rld_pkg::PH_ZERO_LO;
        end else if (word == rld_pkg::FLAG_LITERAL) begin
          state_next.phase = rld_pkg::PH_LIT_LO;
        end else begin
          state_next.phase = rld_pkg::PH_FLAG_LO;
        end
      end
      rld_pkg::PH_ZERO_LO: begin
        state_next.low_byte_hold = data_byte;
        state_next.phase         = rld_pkg::PH_ZERO_HI;
      end
      rld_pkg::PH_LIT_LO: begin
        state_next.low_byte_hold = data_byte;
        state_next.phase         = rld_pkg::PH_LIT_HI;
      end
      rld_pkg::PH_ZERO_HI: begin
        emit = (word != '0);
        run  = lit_load;
      end
      rld_pkg::PH_LIT_HI: begin
        state_next.literal_remaining = lit_load;
        state_next.phase = (lit_load != '0) ? rld_pkg::PH_LIT_DATA : rld_pkg::PH_FLAG_LO;
      end
      rld_pkg::PH_LIT_DATA: begin
        emit                         = 1'b1;
        value                        = data_byte;
        state_next.literal_remaining = lit_dec;
        state_next.phase = (lit_dec != '0) ? rld_pkg::PH_LIT_DATA : rld_pkg::PH_FLAG_LO;
      end
      default: begin
        state_next.low_byte_hold = data_byte;
        state_next.phase         = rld_pkg::PH_FLAG_HI;
      end
    endcase
  end

  assign pos_e = END_W'(pos);
  assign end_e = pos_e + END_W'(run);
  assign ovf   = end_e > FRAME_E;
  assign idx_e = (pos_e > CAP_E) ? CAP_E : pos_e;

  assign result = {emit, idx_e[rld_pkg::INDEX_W-1:0], value, run, ovf};

  always_comb begin
    if (emit) begin
      position_next = ovf ? FRAME_E[POS_W-1:0] : end_e[POS_W-1:0];
    end else begin
      position_next = pos;
    end
  end

endmodule

/* hdl/spk_run_length_decoder.sv */
// Top level of the run-length decoder for compressed palette images.
//
// Input channel: one stream byte per beat (data_byte), with start_of_image
// set on the first byte of an image to restart decoding at pixel zero.
// Output channel: one beat per run: pixel_index, pixel_value, run_length and
// index_overflow. Transparent commands with a nonzero count give one beat of
// value zero; literal commands give one beat of length one per literal byte.
// Other bytes give no beat.
// Path: an accepted byte is held in the input register while the decode step
// updates state, and its run is registered in the output register.
// Throughput: one byte per cycle while the output is not stalled.
// Reset: decoding returns to the flag low byte, position and pending
// literal count go to zero, both channels are empty.
// Stall: while out_ready is low the run beat holds; the byte in the input
// register waits and in_ready drops once it is full.
module spk_run_length_decoder #(
  parameter int FRAME_PIXELS = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [17:0] pixel_index,
  output logic [7:0]  pixel_value,
  output logic [16:0] run_length,
  output logic        index_overflow
);

  localparam int POS_W = $clog2(FRAME_PIXELS + 1);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_start;
  logic                 advance;
  rld_pkg::rld_state_t  state;
  rld_pkg::rld_state_t  state_next;
  logic [POS_W-1:0]     position;
  logic [POS_W-1:0]     position_next;
  rld_pkg::rld_result_t result;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  rld_step #(
    .FRAME_PIXELS(FRAME_PIXELS),
    .POS_W       (POS_W)
  ) u_step (
    .state         (state),
    .position      (position),
    .data_byte     (s1_byte),
    .start_of_image(s1_start),
    .state_next    (state_next),
    .position_next (position_next),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte  <= data_byte;
      s1_start <= start_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= rld_pkg::PH_FLAG_LO;
      state.low_byte_hold     <= '0;
      state.literal_remaining <= '0;
      position                <= '0;
    end else if (advance && s1_valid) begin
      state    <= state_next;
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && result.emit) begin
      pixel_index    <= result.pixel_index;
      pixel_value    <= result.pixel_value;
      run_length     <= result.run_length;
      index_overflow <= result.index_overflow;
    end
  end

endmodule

/* hdl/rld_checker.sv */
// Port-level checks for the run-length decoder, bound to the top level.
module rld_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [17:0] pixel_index,
  input logic [7:0]  pixel_value,
  input logic [16:0] run_length,
  input logic        index_overflow
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present right after reset");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_length != 17'd0)
    else $error("run of zero length");

  a_long_run_transparent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_length != 17'd1) |-> (pixel_value == 8'd0 && run_length[0] == 1'b0))
    else $error("long run is not an even transparent run");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pixel_index)
      && $stable(pixel_value) && $stable(run_length) && $stable(index_overflow)))
    else $error("stalled output beat changed");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !in_ready) |=> !in_ready || out_ready)
    else $error("input reopened while output still stalled");

endmodule

bind spk_run_length_decoder rld_checker u_rld_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pixel_index   (pixel_index),
  .pixel_value   (pixel_value),
  .run_length    (run_length),
  .index_overflow(index_overflow)
);

/* bench/rld_run_checker.sv */
// Watches both channels of the run-length decoder, predicts each run beat and compares.
`timescale 1ns / 1ps
module rld_run_checker #(
  parameter int FRAME_PIXELS = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_image,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [17:0] pixel_index,
  input  logic [7:0]  pixel_value,
  input  logic [16:0] run_length,
  input  logic        index_overflow,
  output int          mismatches,
  output int          pending
);

  localparam longint unsigned INDEX_CAP =
      (FRAME_PIXELS - 1 > rld_pkg::INDEX_MAX) ? rld_pkg::INDEX_MAX : FRAME_PIXELS - 1;

  rld_pkg::phase_t             phase;
  logic [rld_pkg::BYTE_W-1:0]  low_hold;
  logic [rld_pkg::RUN_W-1:0]   lit_left;
  longint unsigned             position;
  rld_pkg::rld_result_t        expected_runs[$];
  rld_pkg::rld_result_t        want;
  int                          err_count = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic queue_run(input logic [rld_pkg::BYTE_W-1:0] value,
                           input logic [rld_pkg::RUN_W-1:0] run);
    rld_pkg::rld_result_t r;
    longint unsigned      stop;
    stop             = position + run;
    r.emit           = 1'b1;
    r.pixel_index    = (position > INDEX_CAP) ? INDEX_CAP[rld_pkg::INDEX_W-1:0]
                                              : position[rld_pkg::INDEX_W-1:0];
    r.pixel_value    = value;
    r.run_length     = run;
    r.index_overflow = (stop > FRAME_PIXELS);
    position         = r.index_overflow ? FRAME_PIXELS : stop;
    expected_runs.push_back(r);
  endtask

  task automatic decode_byte(input logic [rld_pkg::BYTE_W-1:0] b, input logic sof);
    logic [rld_pkg::WORD_W-1:0] word;
    if (sof) begin
      phase    = rld_pkg::PH_FLAG_LO;
      lit_left = '0;
      position = 0;
    end
    word = {b, low_hold};
    case (phase)
      rld_pkg::PH_FLAG_HI: begin
        if (word == rld_pkg::FLAG_ZERO_RUN) phase = rld_pkg::PH_ZERO_LO;
        else if (word == rld_pkg::FLAG_LITERAL) phase = rld_pkg::PH_LIT_LO;
        else phase = rld_pkg::PH_FLAG_LO;
      end
      rld_pkg::PH_ZERO_LO: begin
        low_hold = b;
        phase    = rld_pkg::PH_ZERO_HI;
      end
      rld_pkg::PH_LIT_LO: begin
        low_hold = b;
        phase    = rld_pkg::PH_LIT_HI;
      end
      rld_pkg::PH_ZERO_HI: begin
        phase = rld_pkg::PH_FLAG_LO;
        if (word != '0) queue_run('0, {word, 1'b0});
      end
      rld_pkg::PH_LIT_HI: begin
        lit_left = {word, 1'b0};
        phase    = (lit_left != '0) ? rld_pkg::PH_LIT_DATA : rld_pkg::PH_FLAG_LO;
      end
      rld_pkg::PH_LIT_DATA: begin
        queue_run(b, 17'd1);
        lit_left = lit_left - rld_pkg::RUN_W'(1);
        if (lit_left == '0) phase = rld_pkg::PH_FLAG_LO;
      end
      default: begin
        low_hold = b;
        phase    = rld_pkg::PH_FLAG_HI;
      end
    endcase
  endtask

  task automatic report(input string field, input int unsigned exp_val,
                        input int unsigned got_val);
    if (exp_val != got_val) begin
      err_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase    = rld_pkg::PH_FLAG_LO;
      low_hold = '0;
      lit_left = '0;
      position = 0;
      expected_runs.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(data_byte, start_of_image);
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          err_count++;
          $display("%0t: run beat expected none actual index=%0d value=%0d length=%0d ovf=%0d",
                   $time, pixel_index, pixel_value, run_length, index_overflow);
        end else begin
          want = expected_runs.pop_front();
          report("pixel_index", 32'(want.pixel_index), 32'(pixel_index));
          report("pixel_value", 32'(want.pixel_value), 32'(pixel_value));
          report("run_length", 32'(want.run_length), 32'(run_length));
          report("index_overflow", 32'(want.index_overflow), 32'(index_overflow));
        end
      end
    end
    mismatches <= err_count;
    pending    <= expected_runs.size();
  end

endmodule

/* bench/spk_run_length_decoder_tb.sv */
// Stimulus, flow control and verdict for the run-length decoder regression.
`timescale 1ns / 1ps
module spk_run_length_decoder_tb;

  localparam int FRAME_PIXELS = 262144;
  localparam int STREAM_BYTES = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        start_of_image = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [17:0] pixel_index;
  logic [7:0]  pixel_value;
  logic [16:0] run_length;
  logic        index_overflow;

  int   mismatches;
  int   pending;
  int   tx_idle_pct = 22;
  int   rx_idle_pct = 75;
  int   bytes_sent = 0;
  int   stuck_cycles = 0;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spk_run_length_decoder #(.FRAME_PIXELS(FRAME_PIXELS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .start_of_image(start_of_image),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_index(pixel_index), .pixel_value(pixel_value),
    .run_length(run_length), .index_overflow(index_overflow)
  );

  rld_run_checker #(.FRAME_PIXELS(FRAME_PIXELS)) run_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .start_of_image(start_of_image),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_index(pixel_index), .pixel_value(pixel_value),
    .run_length(run_length), .index_overflow(index_overflow),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    start_of_image <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] w, input logic sof);
    send_byte(w[7:0], sof);
    send_byte(w[15:8], 1'b0);
  endtask

  initial begin
    logic [15:0] count;
    logic        sof;
    logic        need_sof;
    int          kind;

    need_sof = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_word(rld_pkg::FLAG_ZERO_RUN, 1'b1);
    send_word(16'd1, 1'b0);
    send_word(rld_pkg::FLAG_LITERAL, 1'b0);
    send_word(16'd1, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_word(rld_pkg::FLAG_ZERO_RUN, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(rld_pkg::FLAG_LITERAL, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(rld_pkg::FLAG_ZERO_RUN, 1'b0);
    send_word(16'hFFFF, 1'b0);

    while (bytes_sent < STREAM_BYTES) begin
      if (bytes_sent >= 2 * STREAM_BYTES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end else if (bytes_sent >= STREAM_BYTES / 3) begin
        tx_idle_pct = 75;
        rx_idle_pct <= 22;
        hold_go = 1'b1;
      end
      kind     = $urandom_range(99);
      sof      = need_sof || ($urandom_range(29) == 0);
      need_sof = 1'b0;
      if (kind < 45) begin
        if ($urandom_range(19) == 0) count = '0;
        else if ($urandom_range(1) == 0) count = 16'($urandom_range(32768, 65535));
        else if ($urandom_range(3) == 0) count = 16'($urandom_range(65535));
        else count = 16'($urandom_range(1, 8));
        send_word(rld_pkg::FLAG_ZERO_RUN, sof);
        send_word(count, 1'b0);
      end else if (kind < 80) begin
        count = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
        send_word(rld_pkg::FLAG_LITERAL, sof);
        send_word(count, 1'b0);
        repeat (2 * count) send_byte(8'($urandom_range(255)), 1'b0);
      end else if (kind < 88) begin
        count = 16'($urandom_range(65535));
        if (count == rld_pkg::FLAG_ZERO_RUN || count == rld_pkg::FLAG_LITERAL) begin
          count = count ^ 16'h0100;
        end
        send_word(count, sof);
      end else if (kind < 94) begin
        if ($urandom_range(1) == 0) begin
          count     = 16'($urandom_range(3, 65535));
          count[15] = 1'($urandom_range(1));
          send_word(rld_pkg::FLAG_LITERAL, sof);
          send_word(count, 1'b0);
          repeat ($urandom_range(5)) send_byte(8'($urandom_range(255)), 1'b0);
        end else begin
          send_word(rld_pkg::FLAG_ZERO_RUN, sof);
          send_byte(8'($urandom_range(255)), 1'b0);
        end
        need_sof = 1'b1;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
      end
    end
    in_valid <= 1'b0;

    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rld_pkg.sv
hdl/rld_step.sv
hdl/spk_run_length_decoder.sv
hdl/rld_checker.sv
bench/rld_run_checker.sv
bench/spk_run_length_decoder_tb.sv
